/* hw/rtl/pctf_pkg.sv */
// ============================================================================
// pctf_pkg
// Shared types and constants of the posting count threshold filter: item
// layouts, command and register codes, counter store geometry.
// ============================================================================
`default_nettype none

package pctf_pkg;

    // Counter store geometry
    localparam int CHUNK_SIZE  = 65536;
    localparam int GROUP_SIZE  = 32;
    localparam int ADDR_W      = $clog2(CHUNK_SIZE);
    localparam int OFFS_W      = $clog2(GROUP_SIZE);
    localparam int GROUP_W     = ADDR_W - OFFS_W;
    localparam int CNT_W       = 8;
    localparam int ENTRY_W     = ADDR_W + 1;

    // Configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 17;
    localparam int MIN_COUNT_W = 8;

    localparam logic [CNT_W-1:0]       CNT_MAX           = '1;
    localparam logic [MIN_COUNT_W-1:0] MIN_COUNT_RESET   = MIN_COUNT_W'(2);
    localparam logic [ENTRY_W-1:0]     ENTRY_COUNT_RESET = ENTRY_W'(CHUNK_SIZE);

    typedef enum logic [0:0] {
        CMD_COUNT = 1'b0,
        CMD_SCAN  = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_COUNT   = 1'b0,
        REG_ENTRY_COUNT = 1'b1
    } cfg_reg_t;

    // One input item
    typedef struct packed {
        cmd_t               command;
        logic [15:0]        object_id;
        logic [10:0]        group_index;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic [15:0]        candidate_id;
        logic               hit;
        logic               last;
    } out_item_t;

    // Memory access issued into the read-modify-write pipeline
    typedef struct packed {
        logic               valid;
        logic               scan;
        logic               last;
        logic [ADDR_W-1:0]  addr;
    } iss_t;

    // Counter value returned by the pipeline, forwarding applied
    typedef struct packed {
        logic               valid;
        logic               scan;
        logic               last;
        logic [ADDR_W-1:0]  id;
        logic [CNT_W-1:0]   count;
    } rd_t;

endpackage

`default_nettype wire

/* hw/rtl/pctf_ram.sv */
// ============================================================================
// pctf_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered (old data on a same-address collision).
// ============================================================================
`default_nettype none

module pctf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pctf_rmw.sv */
// ============================================================================
// pctf_rmw
// Read-modify-write pipeline around the counter store: read one counter,
// increment it (count) or clear it (scan) and write it back after the read,
// with forwarding of the last write. Runs the clearing pass after reset.
// ============================================================================
`default_nettype none

module pctf_rmw
    import pctf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire iss_t iss,
    output rd_t       rd,
    output logic      clearing
);

    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    iss_t              s1_reg;
    logic              wb_valid_reg;
    logic [ADDR_W-1:0] wb_addr_reg;
    logic [CNT_W-1:0]  wb_data_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;
    logic [CNT_W-1:0]  ram_q;
    logic [CNT_W-1:0]  cnt_eff;
    logic [CNT_W-1:0]  cnt_new;

    pctf_ram #(
        .WIDTH (CNT_W),
        .DEPTH (CHUNK_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (iss.valid),
        .raddr (iss.addr),
        .rdata (ram_q)
    );

    // Forward the write that collided with this read
    assign cnt_eff = (wb_valid_reg && (wb_addr_reg == s1_reg.addr)) ? wb_data_reg : ram_q;

    // Saturating increment for count, zero for scan
    always_comb
    begin
        if (s1_reg.scan)
        begin
            cnt_new = '0;
        end
        else if (cnt_eff == CNT_MAX)
        begin
            cnt_new = cnt_eff;
        end
        else
        begin
            cnt_new = cnt_eff + CNT_W'(1);
        end
    end

    // Select write source: clearing pass or write-back
    always_comb
    begin
        if (clr_active_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = s1_reg.valid;
            ram_waddr = s1_reg.addr;
            ram_wdata = cnt_new;
        end
    end

    // Advance clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(CHUNK_SIZE - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Pipeline stage and write-back record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg       <= '0;
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg       <= iss;
            wb_valid_reg <= s1_reg.valid && !clr_active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wb_addr_reg <= s1_reg.addr;
        wb_data_reg <= cnt_new;
    end

    assign rd.valid = s1_reg.valid;
    assign rd.scan  = s1_reg.scan;
    assign rd.last  = s1_reg.last;
    assign rd.id    = s1_reg.addr;
    assign rd.count = cnt_eff;

    assign clearing = clr_active_reg;

endmodule

`default_nettype wire

/* hw/rtl/pctf_emit.sv */
// ============================================================================
// pctf_emit
// Result formatter: tests each scanned counter against the thresholds and
// holds one hit back so the final result of a scan carries the last flag.
// ============================================================================
`default_nettype none

module pctf_emit
    import pctf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire rd_t                    rd,
    input  wire logic [MIN_COUNT_W-1:0] min_count,
    input  wire logic [ENTRY_W-1:0]     entry_count,
    output out_item_t                   result,
    output logic                        strobe
);

    logic              pend_valid_reg;
    logic              pend_valid_next;
    logic [ADDR_W-1:0] pend_id_reg;
    logic              flush_reg;
    logic              strobe_reg;
    logic              strobe_next;
    out_item_t         result_reg;
    out_item_t         result_next;
    logic              hit_now;

    // Threshold test on the counter read this cycle
    assign hit_now = rd.valid && rd.scan
                     && ({1'b0, rd.id} < entry_count)
                     && (rd.count >= min_count);

    always_comb
    begin
        strobe_next     = 1'b0;
        result_next     = result_reg;
        pend_valid_next = pend_valid_reg;
        if (flush_reg)
        begin
            // Close the scan: held hit or empty result
            strobe_next              = 1'b1;
            result_next.candidate_id = pend_valid_reg ? pend_id_reg : '0;
            result_next.hit          = pend_valid_reg;
            result_next.last         = 1'b1;
            pend_valid_next          = 1'b0;
        end
        else if (hit_now)
        begin
            // Release the previous hit, hold this one
            strobe_next              = pend_valid_reg;
            result_next.candidate_id = pend_id_reg;
            result_next.hit          = 1'b1;
            result_next.last         = 1'b0;
            pend_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            flush_reg      <= 1'b0;
        end
        else
        begin
            strobe_reg     <= strobe_next;
            pend_valid_reg <= pend_valid_next;
            flush_reg      <= rd.valid && rd.scan && rd.last;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (hit_now && !flush_reg)
        begin
            pend_id_reg <= rd.id;
        end
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule

`default_nettype wire

/* hw/rtl/posting_count_threshold_filter_core.sv */
// ============================================================================
// posting_count_threshold_filter_core
// Scan-count candidate filter: per-id occurrence counters in one memory,
// incremented by count items, thresholded and cleared by scan items.
// ============================================================================
// Usage:
//   An item is taken when start is high and busy is low. A count item
//   (command 0) bumps the 8-bit counter of object_id, saturating at 255,
//   and yields no result. A scan item (command 1) reads and clears the 32
//   counters of group_index and emits each id below entry_count whose
//   count reached min_count, in ascending order, last flag on the final
//   one; a scan without hits emits one result with hit 0 and last 1.
//   Results appear on result for one cycle each, marked by strobe; the
//   receiver cannot hold them off.
//   Throughput: count items go one per cycle while busy is low; the
//   counter memory is read, then written back from the registered read
//   data, with the last write forwarded. A scan keeps busy high while it
//   makes one memory read per id of the group, so no item is taken until
//   its last read has left the read stage; its final result follows.
//   Reset: min_count 2, entry_count 65536; a clearing pass then zeroes the
//   counter memory, one entry a cycle, with busy high throughout.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
// ============================================================================
`default_nettype none

module posting_count_threshold_filter_core
    import pctf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire in_item_t              item,
    output out_item_t                  result,
    output logic                       strobe,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [MIN_COUNT_W-1:0] min_count_reg;
    logic [ENTRY_W-1:0]     entry_count_reg;
    logic                   scan_active_reg;
    logic [GROUP_W-1:0]     group_reg;
    logic [OFFS_W-1:0]      offs_reg;
    logic                   accept;
    logic                   clearing;
    iss_t                   iss;
    rd_t                    rd;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_count_reg   <= MIN_COUNT_RESET;
            entry_count_reg <= ENTRY_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_COUNT:   min_count_reg   <= cfg_data[MIN_COUNT_W-1:0];
                REG_ENTRY_COUNT: entry_count_reg <= cfg_data[ENTRY_W-1:0];
                default:         ;
            endcase
        end
    end

    // Hold off items during clearing and while a scan is in flight
    assign busy   = clearing || scan_active_reg || (rd.valid && rd.scan);
    assign accept = start && !busy;

    // Scan sequencer: walk the group, one id a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_active_reg <= 1'b0;
        end
        else if (accept && (item.command == CMD_SCAN))
        begin
            scan_active_reg <= 1'b1;
        end
        else if (scan_active_reg && (offs_reg == OFFS_W'(GROUP_SIZE - 1)))
        begin
            scan_active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (item.command == CMD_SCAN))
        begin
            group_reg <= item.group_index[GROUP_W-1:0];
            offs_reg  <= '0;
        end
        else if (scan_active_reg)
        begin
            offs_reg <= offs_reg + OFFS_W'(1);
        end
    end

    // Issue memory accesses
    assign iss.valid = (accept && (item.command == CMD_COUNT)) || scan_active_reg;
    assign iss.scan  = scan_active_reg;
    assign iss.last  = scan_active_reg && (offs_reg == OFFS_W'(GROUP_SIZE - 1));
    assign iss.addr  = scan_active_reg ? {group_reg, offs_reg} : item.object_id[ADDR_W-1:0];

    pctf_rmw u_rmw (
        .clk      (clk),
        .rst_n    (rst_n),
        .iss      (iss),
        .rd       (rd),
        .clearing (clearing)
    );

    pctf_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd          (rd),
        .min_count   (min_count_reg),
        .entry_count (entry_count_reg),
        .result      (result),
        .strobe      (strobe)
    );

    // Checks
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.hit |-> result.last && (result.candidate_id == '0))
        else $error("empty scan result not final or id nonzero");

    a_scan_holds_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.command == CMD_SCAN) |=> busy)
        else $error("busy low right after taking a scan");

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !strobe && !rd.valid)
        else $error("result or memory access during clearing pass");

    a_scan_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        scan_active_reg && iss.last |=> !scan_active_reg)
        else $error("scan sequencer ran past the end of the group");

endmodule

`default_nettype wire
